// ===== design/assert_macros.svh =====
// assertion macros shared by the scanner modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property every clock while out of reset
`define PLEX_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// check an implication every clock while out of reset
`define PLEX_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ===== design/plex_pkg.sv =====
// types, token codes and keyword table for the pascal subset scanner
`default_nettype none
package plex_pkg;

	typedef struct packed {
		logic [7:0] char_code;
		logic       is_end;
	} chr_t;

	typedef struct packed {
		logic [3:0]  kind;
		logic [4:0]  keyword_code;
		logic [63:0] text;
		logic [7:0]  text_length;
		logic        last;
	} tok_t;

	typedef enum logic [3:0] {
		M_IDLE     = 4'd0,
		M_IDENT    = 4'd1,
		M_INT      = 4'd2,
		M_DOT      = 4'd3,
		M_FRAC     = 4'd4,
		M_STR      = 4'd5,
		M_COLON    = 4'd6,
		M_LPAREN   = 4'd7,
		M_CMT      = 4'd8,
		M_CMT_STAR = 4'd9
	} scan_mode_t;

	localparam logic [3:0] K_END     = 4'd0;
	localparam logic [3:0] K_IDENT   = 4'd1;
	localparam logic [3:0] K_NUMBER  = 4'd2;
	localparam logic [3:0] K_STRING  = 4'd3;
	localparam logic [3:0] K_COLON   = 4'd4;
	localparam logic [3:0] K_ASSIGN  = 4'd5;
	localparam logic [3:0] K_LPAREN  = 4'd6;
	localparam logic [3:0] K_RPAREN  = 4'd7;
	localparam logic [3:0] K_SEMI    = 4'd8;
	localparam logic [3:0] K_DOT     = 4'd9;
	localparam logic [3:0] K_ADDOP   = 4'd10;
	localparam logic [3:0] K_MULOP   = 4'd11;
	localparam logic [3:0] K_RELOP   = 4'd12;
	localparam logic [3:0] K_KEYWORD = 4'd13;
	localparam logic [3:0] K_ILLEGAL = 4'd14;

	localparam int unsigned MAX_TOKS = 3;

	// packed word, first character in the low byte; 0 when not a keyword
	function automatic logic [4:0] kw_code(input logic [63:0] w);
		logic [4:0] r;
		begin
			r = 5'd0;
			case (w)
				64'h00_6d_61_72_67_6f_72_70: r = 5'd13; // program
				64'h00_00_00_6e_69_67_65_62: r = 5'd14; // begin
				64'h00_00_00_00_00_64_6e_65: r = 5'd15; // end
				64'h00_00_00_74_73_6e_6f_63: r = 5'd16; // const
				64'h00_00_00_00_00_72_61_76: r = 5'd17; // var
				64'h00_00_00_65_6c_69_68_77: r = 5'd18; // while
				64'h00_00_00_00_00_00_6f_64: r = 5'd19; // do
				64'h00_00_00_00_00_00_66_69: r = 5'd20; // if
				64'h00_00_00_00_6e_65_68_74: r = 5'd21; // then
				64'h00_72_65_67_65_74_6e_69: r = 5'd22; // integer
				64'h00_00_00_00_6c_61_65_72: r = 5'd22; // real
				64'h00_6e_61_65_6c_6f_6f_62: r = 5'd22; // boolean
				64'h00_00_00_00_00_64_6f_6d: r = 5'd11; // mod
				64'h00_00_00_00_00_76_69_64: r = 5'd11; // div
				64'h00_00_00_00_00_64_6e_61: r = 5'd11; // and
				64'h00_00_00_00_00_00_72_6f: r = 5'd10; // or
				64'h00_00_00_00_00_74_6f_6e: r = 5'd23; // not
				64'h00_00_00_65_74_69_72_77: r = 5'd24; // write
				64'h00_6e_6c_65_74_69_72_77: r = 5'd24; // writeln
				64'h00_00_00_00_64_61_65_72: r = 5'd25; // read
				64'h00_00_00_00_65_75_72_74: r = 5'd2;  // true
				64'h00_00_00_65_73_6c_61_66: r = 5'd2;  // false
				default: r = 5'd0;
			endcase
			return r;
		end
	endfunction

endpackage
`default_nettype wire

// ===== design/plex_scan.sv =====
// scan state and single-pass token decode for one character request
`default_nettype none
`include "assert_macros.svh"
module plex_scan (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             acc,
	input  wire plex_pkg::chr_t   chr,
	output plex_pkg::tok_t        toks [plex_pkg::MAX_TOKS],
	output logic [1:0]            tok_n
);

	plex_pkg::scan_mode_t mode_q, m;
	logic [63:0] buf_q, b;
	logic [7:0]  cnt_q, k;
	logic        dq_q, d;
	logic        pend, dotf, go;
	logic [3:0]  pk;
	logic [4:0]  kw;
	logic [7:0]  c;
	logic [1:0]  n;

	function automatic logic [63:0] put_b(input logic [63:0] bb, input logic [7:0] kk,
		input logic [7:0] cc);
		logic [63:0] r;
		begin
			r = bb;
			if (kk < 8'd8) r[kk[2:0]*8 +: 8] = cc;
			return r;
		end
	endfunction

	function automatic logic [7:0] put_k(input logic [7:0] kk);
		return (kk == 8'd255) ? kk : kk + 8'd1;
	endfunction

	function automatic plex_pkg::tok_t mk(input logic [3:0] kd, input logic [4:0] kc,
		input logic [63:0] tx, input logic [7:0] ln);
		plex_pkg::tok_t r;
		begin
			r.kind = kd;
			r.keyword_code = kc;
			r.text = tx;
			r.text_length = ln;
			r.last = 1'b0;
			return r;
		end
	endfunction

	function automatic logic is_dig(input logic [7:0] x);
		return x >= "0" && x <= "9";
	endfunction

	function automatic logic is_let(input logic [7:0] x);
		return (x >= "a" && x <= "z") || (x >= "A" && x <= "Z");
	endfunction

	always_comb begin
		b = buf_q;
		k = cnt_q;
		m = mode_q;
		d = dq_q;
		c = chr.char_code;
		n = 2'd0;
		pend = 1'b0;
		pk = plex_pkg::K_IDENT;
		dotf = 1'b0;
		go = 1'b0;
		kw = 5'd0;
		for (int i = 0; i < plex_pkg::MAX_TOKS; i++) toks[i] = '0;
		if (chr.is_end) begin
			case (mode_q)
				plex_pkg::M_IDENT: pend = 1'b1;
				plex_pkg::M_INT, plex_pkg::M_FRAC: begin
					pend = 1'b1;
					pk = plex_pkg::K_NUMBER;
				end
				plex_pkg::M_DOT: begin
					pend = 1'b1;
					pk = plex_pkg::K_NUMBER;
					dotf = 1'b1;
				end
				plex_pkg::M_STR: begin
					pend = 1'b1;
					pk = plex_pkg::K_STRING;
				end
				plex_pkg::M_COLON: begin
					pend = 1'b1;
					pk = plex_pkg::K_COLON;
				end
				plex_pkg::M_LPAREN: begin
					pend = 1'b1;
					pk = plex_pkg::K_LPAREN;
				end
				default: pend = 1'b0;
			endcase
		end else begin
			case (mode_q)
				plex_pkg::M_IDENT: begin
					if (is_let(c) || is_dig(c)) begin
						b = put_b(b, k, (c >= "A" && c <= "Z") ? c + 8'd32 : c);
						k = put_k(k);
					end else begin
						pend = 1'b1;
						go = 1'b1;
					end
				end
				plex_pkg::M_INT: begin
					if (is_dig(c)) begin
						b = put_b(b, k, c);
						k = put_k(k);
					end else if (c == ".") begin
						m = plex_pkg::M_DOT;
					end else begin
						pend = 1'b1;
						pk = plex_pkg::K_NUMBER;
						go = 1'b1;
					end
				end
				plex_pkg::M_DOT: begin
					if (is_dig(c)) begin
						b = put_b(b, k, ".");
						k = put_k(k);
						b = put_b(b, k, c);
						k = put_k(k);
						m = plex_pkg::M_FRAC;
					end else begin
						pend = 1'b1;
						pk = plex_pkg::K_NUMBER;
						dotf = 1'b1;
						go = 1'b1;
					end
				end
				plex_pkg::M_FRAC: begin
					if (is_dig(c)) begin
						b = put_b(b, k, c);
						k = put_k(k);
					end else begin
						pend = 1'b1;
						pk = plex_pkg::K_NUMBER;
						go = 1'b1;
					end
				end
				plex_pkg::M_STR: begin
					b = put_b(b, k, c);
					k = put_k(k);
					if ((dq_q && c == "\"") || (!dq_q && c == "'")) begin
						pend = 1'b1;
						pk = plex_pkg::K_STRING;
						m = plex_pkg::M_IDLE;
					end
				end
				plex_pkg::M_COLON: begin
					pend = 1'b1;
					if (c == "=") begin
						b = put_b(b, k, c);
						k = put_k(k);
						pk = plex_pkg::K_ASSIGN;
						m = plex_pkg::M_IDLE;
					end else begin
						pk = plex_pkg::K_COLON;
						go = 1'b1;
					end
				end
				plex_pkg::M_LPAREN: begin
					if (c == "*") begin
						b = '0;
						k = '0;
						m = plex_pkg::M_CMT;
					end else begin
						pend = 1'b1;
						pk = plex_pkg::K_LPAREN;
						go = 1'b1;
					end
				end
				plex_pkg::M_CMT: begin
					if (c == "*") m = plex_pkg::M_CMT_STAR;
				end
				plex_pkg::M_CMT_STAR: begin
					if (c == ")") m = plex_pkg::M_IDLE;
					else if (c != "*") m = plex_pkg::M_CMT;
				end
				default: go = 1'b1;
			endcase
		end

		if (pend) begin
			if (pk == plex_pkg::K_IDENT) begin
				kw = plex_pkg::kw_code(b);
				if (kw != 5'd0) pk = plex_pkg::K_KEYWORD;
			end
			toks[n] = mk(pk, kw, b, k);
			n = n + 2'd1;
			b = '0;
			k = '0;
		end
		if (dotf) begin
			toks[n] = mk(plex_pkg::K_DOT, 5'd0, 64'(8'h2e), 8'd1);
			n = n + 2'd1;
		end
		if (chr.is_end) begin
			toks[n] = mk(plex_pkg::K_END, 5'd0, 64'd0, 8'd0);
			n = n + 2'd1;
			m = plex_pkg::M_IDLE;
			b = '0;
			k = '0;
			d = 1'b0;
		end else if (go) begin
			b = '0;
			k = '0;
			m = plex_pkg::M_IDLE;
			if (is_let(c)) begin
				b = put_b(b, k, (c >= "A" && c <= "Z") ? c + 8'd32 : c);
				k = put_k(k);
				m = plex_pkg::M_IDENT;
			end else if (is_dig(c)) begin
				b = put_b(b, k, c);
				k = put_k(k);
				m = plex_pkg::M_INT;
			end else if (c == "\"" || c == "'") begin
				b = put_b(b, k, c);
				k = put_k(k);
				d = (c == "\"");
				m = plex_pkg::M_STR;
			end else if (c == ":") begin
				b = put_b(b, k, c);
				k = put_k(k);
				m = plex_pkg::M_COLON;
			end else if (c == "(") begin
				b = put_b(b, k, c);
				k = put_k(k);
				m = plex_pkg::M_LPAREN;
			end else if (c == " " || c == 8'h09 || c == 8'h0a) begin
				m = plex_pkg::M_IDLE;
			end else begin
				if (c == ")") pk = plex_pkg::K_RPAREN;
				else if (c == ";") pk = plex_pkg::K_SEMI;
				else if (c == ".") pk = plex_pkg::K_DOT;
				else if (c == "+" || c == "-") pk = plex_pkg::K_ADDOP;
				else if (c == "*" || c == "/") pk = plex_pkg::K_MULOP;
				else if (c == "<" || c == ">" || c == "=") pk = plex_pkg::K_RELOP;
				else pk = plex_pkg::K_ILLEGAL;
				toks[n] = mk(pk, 5'd0, 64'(c), 8'd1);
				n = n + 2'd1;
			end
		end
		if (n != 2'd0) toks[n - 2'd1].last = 1'b1;
		tok_n = n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= plex_pkg::M_IDLE;
			buf_q <= '0;
			cnt_q <= '0;
			dq_q <= 1'b0;
		end else if (acc) begin
			mode_q <= m;
			buf_q <= b;
			cnt_q <= k;
			dq_q <= d;
		end
	end

	`PLEX_IMPLY(a_end_idle, acc && chr.is_end, ##1 (mode_q == plex_pkg::M_IDLE && cnt_q == 8'd0), "scanner not idle after end mark")
	`PLEX_IMPLY(a_end_emits, chr.is_end, tok_n != 2'd0, "end mark produced no token")
	`PLEX_IMPLY(a_cmt_quiet, mode_q == plex_pkg::M_CMT || mode_q == plex_pkg::M_CMT_STAR, chr.is_end || tok_n == 2'd0, "token inside comment")

endmodule
`default_nettype wire

// ===== design/plex_fifo.sv =====
// four-entry token queue, takes up to three tokens a cycle while it has room and hands out one while tok_ready is high
`default_nettype none
`include "assert_macros.svh"
module plex_fifo (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire plex_pkg::tok_t push_tok [plex_pkg::MAX_TOKS],
	input  wire logic [1:0]     push_n,
	output logic                room,
	output logic                tok_valid,
	input  wire logic           tok_ready,
	output plex_pkg::tok_t      tok
);

	plex_pkg::tok_t mem [4];
	logic [1:0] head_q, tail_q;
	logic [2:0] count_q;
	logic       pop;

	assign pop = tok_valid && tok_ready;
	assign tok_valid = count_q != 3'd0;
	assign tok = mem[head_q];
	// three free slots are needed for the worst request
	assign room = count_q <= 3'd1;

	always_ff @(posedge clk) begin
		for (int i = 0; i < plex_pkg::MAX_TOKS; i++) begin
			if (2'(i) < push_n) mem[tail_q + 2'(i)] <= push_tok[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			count_q <= '0;
		end else begin
			tail_q <= tail_q + push_n;
			if (pop) head_q <= head_q + 2'd1;
			count_q <= count_q + {1'b0, push_n} - {2'b00, pop};
		end
	end

	`PLEX_ASSERT(a_cnt_max, count_q <= 3'd4, "queue count beyond depth")
	`PLEX_IMPLY(a_no_ovf, push_n != 2'd0, room, "push without room")
	`PLEX_IMPLY(a_pop_dec, pop && push_n == 2'd0, ##1 (count_q == $past(count_q) - 3'd1), "pop lost")

endmodule
`default_nettype wire

// ===== design/pascal_subset_lexer_unit.sv =====
// a token is written into the output queue when the character request that ends it is accepted
// throughput: one character request per cycle; the output queue hands out one token
// per cycle while tok_ready is high and takes a request only while three slots are free
// reset: arst_n clears scan mode, text buffer and the token queue at once
`default_nettype none
module pascal_subset_lexer_unit #(
	parameter int TEXT_CHARS = 8
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           chr_valid,
	output logic                chr_ready,
	input  wire plex_pkg::chr_t chr,
	output logic                tok_valid,
	input  wire logic           tok_ready,
	output plex_pkg::tok_t      tok
);

	localparam logic [63:0] TextMask = {64{1'b1}} >> (64 - 8 * TEXT_CHARS);

	plex_pkg::tok_t toks [plex_pkg::MAX_TOKS];
	plex_pkg::tok_t qtok;
	logic [1:0] tok_n;
	logic       acc;

	assign acc = chr_valid && chr_ready;

	plex_scan u_scan (
		.clk(clk), .arst_n(arst_n), .acc(acc), .chr(chr), .toks(toks), .tok_n(tok_n)
	);

	plex_fifo u_fifo (
		.clk(clk), .arst_n(arst_n), .push_tok(toks), .push_n(acc ? tok_n : 2'd0),
		.room(chr_ready), .tok_valid(tok_valid), .tok_ready(tok_ready), .tok(qtok)
	);

	always_comb begin
		tok = qtok;
		tok.text = qtok.text & TextMask;
	end

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// self-checking testbench for the pascal subset scanner with its own token predictor
`default_nettype none
module tb;

	typedef struct {
		plex_pkg::chr_t c;
		bit             drain;
	} src_item_t;

	logic           clk;
	logic           arst_n;
	logic           chr_valid;
	logic           chr_ready;
	plex_pkg::chr_t chr;
	logic           tok_valid;
	logic           tok_ready;
	plex_pkg::tok_t tok;

	pascal_subset_lexer_unit i_dut (
		.clk(clk), .arst_n(arst_n),
		.chr_valid(chr_valid), .chr_ready(chr_ready), .chr(chr),
		.tok_valid(tok_valid), .tok_ready(tok_ready), .tok(tok)
	);

	always #5 clk = ~clk;

	src_item_t      src_q[$];
	plex_pkg::tok_t tok_expect_q[$];
	plex_pkg::tok_t step_toks[$];
	int        errors = 0;
	int        chars_sent = 0;
	int        ends_sent = 0;
	int        toks_seen = 0;
	int        kinds_seen[15];

	// predictor state
	plex_pkg::scan_mode_t lex_mode;
	logic [63:0] lex_buf;
	logic [7:0]  lex_cnt;
	bit          lex_dq;

	string kw_names[22] = '{"program", "begin", "end", "const", "var", "while", "do",
		"if", "then", "integer", "real", "boolean", "mod", "div", "and", "or",
		"not", "write", "writeln", "read", "true", "false"};
	logic [4:0] kw_codes[22] = '{5'd13, 5'd14, 5'd15, 5'd16, 5'd17, 5'd18, 5'd19,
		5'd20, 5'd21, 5'd22, 5'd22, 5'd22, 5'd11, 5'd11, 5'd11, 5'd10, 5'd23, 5'd24,
		5'd24, 5'd25, 5'd2, 5'd2};

	function automatic logic [63:0] word_bits(input string s);
		logic [63:0] v;
		v = '0;
		for (int i = 0; i < s.len() && i < 8; i++)
			v[8*i +: 8] = s[i];
		return v;
	endfunction

	function automatic bit is_alpha(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic bit is_num(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	task automatic add_char(input logic [7:0] c);
		if (lex_cnt < 8'd8)
			lex_buf[8*lex_cnt +: 8] = c;
		if (lex_cnt != 8'd255)
			lex_cnt++;
	endtask

	task automatic emit_tok(input logic [3:0] k, input logic [4:0] kw,
			input logic [63:0] t, input logic [7:0] n);
		plex_pkg::tok_t x;
		x.kind = k;
		x.keyword_code = kw;
		x.text = t;
		x.text_length = n;
		x.last = 1'b0;
		step_toks.push_back(x);
	endtask

	task automatic emit_buf(input logic [3:0] k);
		emit_tok(k, 5'd0, lex_buf, lex_cnt);
		lex_buf = '0;
		lex_cnt = '0;
	endtask

	task automatic emit_word();
		logic [4:0] code;
		code = 5'd0;
		for (int i = 0; i < 22; i++)
			if (lex_buf == word_bits(kw_names[i]))
				code = kw_codes[i];
		if (code != 5'd0) begin
			emit_tok(plex_pkg::K_KEYWORD, code, lex_buf, lex_cnt);
			lex_buf = '0;
			lex_cnt = '0;
		end else begin
			emit_buf(plex_pkg::K_IDENT);
		end
	endtask

	task automatic scan_start(input logic [7:0] c);
		lex_buf = '0;
		lex_cnt = '0;
		lex_mode = plex_pkg::M_IDLE;
		if (c == " " || c == 8'd9 || c == 8'd10)
			return;
		if (is_alpha(c)) begin
			add_char((c >= "A" && c <= "Z") ? c + 8'd32 : c);
			lex_mode = plex_pkg::M_IDENT;
		end else if (is_num(c)) begin
			add_char(c);
			lex_mode = plex_pkg::M_INT;
		end else if (c == "\"" || c == "'") begin
			add_char(c);
			lex_dq = (c == "\"");
			lex_mode = plex_pkg::M_STR;
		end else if (c == ":") begin
			add_char(c);
			lex_mode = plex_pkg::M_COLON;
		end else if (c == "(") begin
			add_char(c);
			lex_mode = plex_pkg::M_LPAREN;
		end else if (c == ")") emit_tok(plex_pkg::K_RPAREN, 5'd0, 64'(c), 8'd1);
		else if (c == ";") emit_tok(plex_pkg::K_SEMI, 5'd0, 64'(c), 8'd1);
		else if (c == ".") emit_tok(plex_pkg::K_DOT, 5'd0, 64'(c), 8'd1);
		else if (c == "+" || c == "-") emit_tok(plex_pkg::K_ADDOP, 5'd0, 64'(c), 8'd1);
		else if (c == "*" || c == "/") emit_tok(plex_pkg::K_MULOP, 5'd0, 64'(c), 8'd1);
		else if (c == "<" || c == ">" || c == "=")
			emit_tok(plex_pkg::K_RELOP, 5'd0, 64'(c), 8'd1);
		else emit_tok(plex_pkg::K_ILLEGAL, 5'd0, 64'(c), 8'd1);
	endtask

	task automatic lex_reset();
		lex_mode = plex_pkg::M_IDLE;
		lex_buf = '0;
		lex_cnt = '0;
		lex_dq = 0;
	endtask

	// works out the tokens caused by one request and queues them
	task automatic scan_request(input plex_pkg::chr_t r);
		logic [7:0] c;
		plex_pkg::tok_t t;
		c = r.char_code;
		step_toks.delete();
		if (r.is_end) begin
			case (lex_mode)
				plex_pkg::M_IDENT: emit_word();
				plex_pkg::M_INT, plex_pkg::M_FRAC: emit_buf(plex_pkg::K_NUMBER);
				plex_pkg::M_DOT: begin
					emit_buf(plex_pkg::K_NUMBER);
					emit_tok(plex_pkg::K_DOT, 5'd0, 64'(8'h2e), 8'd1);
				end
				plex_pkg::M_STR: emit_buf(plex_pkg::K_STRING);
				plex_pkg::M_COLON: emit_buf(plex_pkg::K_COLON);
				plex_pkg::M_LPAREN: emit_buf(plex_pkg::K_LPAREN);
				default: ;
			endcase
			emit_tok(plex_pkg::K_END, 5'd0, 64'd0, 8'd0);
			lex_reset();
		end else begin
			case (lex_mode)
				plex_pkg::M_IDENT: begin
					if (is_alpha(c) || is_num(c))
						add_char((c >= "A" && c <= "Z") ? c + 8'd32 : c);
					else begin
						emit_word();
						scan_start(c);
					end
				end
				plex_pkg::M_INT: begin
					if (is_num(c)) add_char(c);
					else if (c == ".") lex_mode = plex_pkg::M_DOT;
					else begin
						emit_buf(plex_pkg::K_NUMBER);
						scan_start(c);
					end
				end
				plex_pkg::M_DOT: begin
					if (is_num(c)) begin
						add_char(".");
						add_char(c);
						lex_mode = plex_pkg::M_FRAC;
					end else begin
						emit_buf(plex_pkg::K_NUMBER);
						emit_tok(plex_pkg::K_DOT, 5'd0, 64'(8'h2e), 8'd1);
						scan_start(c);
					end
				end
				plex_pkg::M_FRAC: begin
					if (is_num(c)) add_char(c);
					else begin
						emit_buf(plex_pkg::K_NUMBER);
						scan_start(c);
					end
				end
				plex_pkg::M_STR: begin
					add_char(c);
					if ((lex_dq && c == "\"") || (!lex_dq && c == "'")) begin
						emit_buf(plex_pkg::K_STRING);
						lex_mode = plex_pkg::M_IDLE;
					end
				end
				plex_pkg::M_COLON: begin
					if (c == "=") begin
						add_char(c);
						emit_buf(plex_pkg::K_ASSIGN);
						lex_mode = plex_pkg::M_IDLE;
					end else begin
						emit_buf(plex_pkg::K_COLON);
						scan_start(c);
					end
				end
				plex_pkg::M_LPAREN: begin
					if (c == "*") begin
						lex_buf = '0;
						lex_cnt = '0;
						lex_mode = plex_pkg::M_CMT;
					end else begin
						emit_buf(plex_pkg::K_LPAREN);
						scan_start(c);
					end
				end
				plex_pkg::M_CMT: if (c == "*") lex_mode = plex_pkg::M_CMT_STAR;
				plex_pkg::M_CMT_STAR: begin
					if (c == ")") lex_mode = plex_pkg::M_IDLE;
					else if (c != "*") lex_mode = plex_pkg::M_CMT;
				end
				default: scan_start(c);
			endcase
		end
		if (step_toks.size() > 0) begin
			t = step_toks[step_toks.size() - 1];
			t.last = 1'b1;
			step_toks[step_toks.size() - 1] = t;
		end
		foreach (step_toks[i])
			tok_expect_q.push_back(step_toks[i]);
	endtask

	task automatic report(input string field, input logic [63:0] got, input logic [63:0] want);
		$display("token %0d: %s got %h want %h", toks_seen, field, got, want);
		errors++;
	endtask

	// stimulus helpers
	task automatic put_byte(input logic [7:0] c);
		src_item_t s;
		s.c.char_code = c;
		s.c.is_end = 1'b0;
		s.drain = 0;
		src_q.push_back(s);
	endtask

	task automatic put_text(input string s);
		for (int i = 0; i < s.len(); i++)
			put_byte(s[i]);
	endtask

	task automatic put_end(input bit drain);
		src_item_t s;
		s.c.char_code = 8'($urandom_range(0, 255));
		s.c.is_end = 1'b1;
		s.drain = drain;
		src_q.push_back(s);
	endtask

	task automatic put_word();
		int n;
		logic [7:0] c;
		if ($urandom_range(0, 2) == 0) begin
			put_text(kw_names[$urandom_range(0, 21)]);
			return;
		end
		n = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 6);
		for (int i = 0; i < n; i++) begin
			if (i > 0 && $urandom_range(0, 3) == 0) c = 8'("0" + $urandom_range(0, 9));
			else if ($urandom_range(0, 1)) c = 8'("a" + $urandom_range(0, 25));
			else c = 8'("A" + $urandom_range(0, 25));
			put_byte(c);
		end
	endtask

	task automatic put_digits(input int n);
		for (int i = 0; i < n; i++)
			put_byte(8'("0" + $urandom_range(0, 9)));
	endtask

	task automatic put_piece();
		string ops = "+-*/<>=;:)(.";
		case ($urandom_range(0, 11))
			0, 1: put_word();
			2: begin
				put_digits($urandom_range(1, 4));
				if ($urandom_range(0, 1)) begin
					put_byte(".");
					if ($urandom_range(0, 2) != 0) put_digits($urandom_range(1, 9));
				end
			end
			3: begin
				logic [7:0] q;
				q = $urandom_range(0, 1) ? "\"" : "'";
				put_byte(q);
				for (int i = $urandom_range(0, 10); i > 0; i--)
					put_byte(8'($urandom_range(0, 255)));
				if ($urandom_range(0, 5) != 0) put_byte(q);
			end
			4: begin
				put_text("(*");
				for (int i = $urandom_range(0, 5); i > 0; i--)
					put_byte($urandom_range(0, 3) == 0 ? 8'h2a : 8'($urandom_range(0, 255)));
				if ($urandom_range(0, 5) != 0) put_text($urandom_range(0, 1) ? "*)" : "**)");
			end
			5: put_text($urandom_range(0, 1) ? ":=" : ":");
			6, 7: put_byte(ops[$urandom_range(0, ops.len() - 1)]);
			8: put_byte(8'($urandom_range(0, 255)));
			9: put_end(0);
			default: begin
				case ($urandom_range(0, 2))
					0: put_byte(" ");
					1: put_byte(8'd9);
					default: put_byte(8'd10);
				endcase
			end
		endcase
	endtask

	// sender
	int  src_gap;
	always @(posedge clk or negedge arst_n) begin
		src_item_t s;
		logic nv;
		if (!arst_n) begin
			chr_valid <= 1'b0;
			chr <= '0;
			src_gap = 0;
		end else begin
			if (chr_valid && chr_ready) begin
				scan_request(chr);
				if (chr.is_end) ends_sent++;
				else chars_sent++;
			end
			if (!chr_valid || chr_ready) begin
				nv = 1'b0;
				if (src_gap > 0) begin
					src_gap--;
				end else if (src_q.size() > 0 && !(src_q[0].drain && tok_expect_q.size() > 0)) begin
					s = src_q.pop_front();
					chr <= s.c;
					nv = 1'b1;
					case ($urandom_range(0, 19))
						0: src_gap = $urandom_range(10, 40);
						1, 2, 3, 4: src_gap = $urandom_range(1, 3);
						default: src_gap = 0;
					endcase
				end
				chr_valid <= nv;
			end
		end
	end

	// one long hold-off of the receiver while the sender keeps going
	int   hold_left;
	bit   held_once;
	logic hold_on;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left = 0;
			held_once = 0;
			hold_on <= 1'b0;
		end else begin
			if (!held_once && chars_sent >= 140) begin
				held_once = 1;
				hold_left = 300;
			end
			if (hold_left > 0) hold_left--;
			hold_on <= (hold_left > 0);
		end
	end

	// receiver and checker
	int  sink_gap;
	always @(posedge clk or negedge arst_n) begin
		plex_pkg::tok_t want;
		if (!arst_n) begin
			tok_ready <= 1'b0;
			sink_gap = 0;
		end else begin
			if (tok_valid && tok_ready) begin
				if (tok_expect_q.size() == 0) begin
					report("unexpected token", 64'(tok.kind), 64'd0);
				end else begin
					want = tok_expect_q.pop_front();
					if (tok.kind != want.kind)
						report("kind", 64'(tok.kind), 64'(want.kind));
					if (tok.keyword_code != want.keyword_code)
						report("keyword_code", 64'(tok.keyword_code), 64'(want.keyword_code));
					if (tok.text != want.text) report("text", tok.text, want.text);
					if (tok.text_length != want.text_length)
						report("text_length", 64'(tok.text_length), 64'(want.text_length));
					if (tok.last != want.last)
						report("last", 64'(tok.last), 64'(want.last));
					if (tok.kind < 4'd15) kinds_seen[tok.kind]++;
				end
				toks_seen++;
			end
			if (hold_on) begin
				tok_ready <= 1'b0;
			end else if (sink_gap > 0) begin
				sink_gap--;
				tok_ready <= 1'b0;
			end else begin
				tok_ready <= 1'b1;
				case ($urandom_range(0, 15))
					0: sink_gap = $urandom_range(8, 30);
					1, 2, 3: sink_gap = $urandom_range(1, 3);
					default: sink_gap = 0;
				endcase
			end
		end
	end

	initial begin
		int kinds_hit;
		clk = 1'b0;
		arst_n = 1'b0;
		lex_reset();

		// directed part
		put_text("Program x1:=12.5;");
		put_end(0);
		put_text("12.a");
		put_byte(8'd13);
		put_byte(8'd0);
		put_byte(8'hFF);
		put_text("(*)x**)");
		put_text("ABCDEFGHIwriteln ");
		put_end(1);
		put_text("(* open");
		put_end(0);
		put_text("\"ab'\n");
		put_end(0);
		put_text("'c\"' 7.");
		put_end(0);
		put_text(":( +-*/<>=");
		put_end(0);
		put_text("x");
		put_end(0);
		put_text(":");
		put_end(0);
		put_text("(");
		put_end(0);
		put_text("3.14");
		put_end(1);
		// random part, with end marks that pause until everything has drained
		while (src_q.size() < 330) begin
			put_piece();
			if (src_q.size() > 220 && src_q.size() < 226) put_end(1);
		end
		put_end(0);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		wait (src_q.size() == 0 && !chr_valid && tok_expect_q.size() == 0);
		repeat (20) @(posedge clk);
		kinds_hit = 0;
		foreach (kinds_seen[i])
			if (kinds_seen[i] > 0) kinds_hit++;
		$display("scanned %0d characters and %0d end marks into %0d tokens", chars_sent,
			ends_sent, toks_seen);
		$display("%0d of 15 token kinds seen, %0d mismatches", kinds_hit, errors);
		if (errors == 0 && tok_expect_q.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#2000000;
		$display("timeout with %0d tokens outstanding", tok_expect_q.size());
		$display("end of test: mismatches");
		$finish;
	end

endmodule
`default_nettype wire

// ===== sim.f =====
+incdir+design
design/plex_pkg.sv
design/plex_scan.sv
design/plex_fifo.sv
design/pascal_subset_lexer_unit.sv
tb/tb.sv
